FILE: sv/jvcl_pkg.sv
// Shared types and constants for the joint velocity command limiter.
// Holds payload structs, controller commands, state and register codes.
// No dependencies.
package jvcl_pkg;

    // Lane count of the payload and default number of active joints
    localparam int unsigned LANES          = 6;
    localparam int unsigned JOINT_COUNT_DEF = 6;

    // Stage registers between joint issue and the result buffer write
    localparam int unsigned PIPE_DEPTH = 5;

    localparam int unsigned IDX_W  = $clog2(LANES);
    localparam int unsigned CNT_W  = $clog2(LANES + PIPE_DEPTH);
    localparam int unsigned CFG_AW = 3;
    localparam int unsigned CFG_DW = 20;

    // Register reset values
    localparam logic [16:0]        ALPHA_RST    = 17'd65536;
    localparam logic [16:0]        ALPHA_ONE    = 17'd65536;
    localparam logic [15:0]        CTIME_RST    = 16'd655;
    localparam logic [19:0]        INV_RST      = 20'd25600;
    localparam logic [14:0]        CLIMIT_RST   = 15'd32767;
    localparam logic [14:0]        VLIMIT_RST   = 15'd32767;
    localparam logic [14:0]        SLIMIT_RST   = 15'd32767;
    localparam logic signed [15:0] POS_MIN_RST  = -16'sd32768;
    localparam logic signed [15:0] POS_MAX_RST  = 16'sd32767;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_ALPHA   = 3'd0,
        CFG_CTIME   = 3'd1,
        CFG_INV     = 3'd2,
        CFG_CLIMIT  = 3'd3,
        CFG_VLIMIT  = 3'd4,
        CFG_SLIMIT  = 3'd5,
        CFG_POS_MIN = 3'd6,
        CFG_POS_MAX = 3'd7
    } t_cfg_idx;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HAND
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic             start;
        logic             issue;
        logic [IDX_W-1:0] issue_idx;
        logic             load_out;
    } t_ctrl_cmd;

    // Input request
    typedef struct packed {
        logic signed [15:0] pos_now_0;
        logic signed [15:0] pos_now_1;
        logic signed [15:0] pos_now_2;
        logic signed [15:0] pos_now_3;
        logic signed [15:0] pos_now_4;
        logic signed [15:0] pos_now_5;
        logic signed [15:0] vel_cmd_0;
        logic signed [15:0] vel_cmd_1;
        logic signed [15:0] vel_cmd_2;
        logic signed [15:0] vel_cmd_3;
        logic signed [15:0] vel_cmd_4;
        logic signed [15:0] vel_cmd_5;
    } t_in_req;

    // Result request
    typedef struct packed {
        logic signed [15:0] pos_next_0;
        logic signed [15:0] pos_next_1;
        logic signed [15:0] pos_next_2;
        logic signed [15:0] pos_next_3;
        logic signed [15:0] pos_next_4;
        logic signed [15:0] pos_next_5;
        logic signed [15:0] vel_eff_0;
        logic signed [15:0] vel_eff_1;
        logic signed [15:0] vel_eff_2;
        logic signed [15:0] vel_eff_3;
        logic signed [15:0] vel_eff_4;
        logic signed [15:0] vel_eff_5;
    } t_out_rsp;

endpackage

FILE: sv/jvcl_ctrl.sv
// Sequencer of the joint velocity command limiter: accepts a request, issues
// one joint per cycle into the datapath, then hands the result to the output.
// Depends on jvcl_pkg.
module jvcl_ctrl #(
    parameter int unsigned JOINT_COUNT = jvcl_pkg::JOINT_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  logic                i_stall,
    output jvcl_pkg::t_ctrl_cmd o_cmd
);

    localparam int unsigned CNT_W = jvcl_pkg::CNT_W;
    localparam int unsigned IDX_W = jvcl_pkg::IDX_W;
    localparam logic [CNT_W-1:0] ISSUE_END = CNT_W'(JOINT_COUNT);
    localparam logic [CNT_W-1:0] LAST      = CNT_W'(JOINT_COUNT + jvcl_pkg::PIPE_DEPTH - 1);

    jvcl_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_vld, n_out_vld;

    // State, counter and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= jvcl_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_out_vld = r_out_vld && i_stall;
        o_cmd     = '0;
        case (r_state)
            jvcl_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = jvcl_pkg::ST_RUN;
                end
            end
            jvcl_pkg::ST_RUN: begin
                // one joint enters per cycle, then wait for the pipe to drain
                o_cmd.issue     = (r_cnt < ISSUE_END);
                o_cmd.issue_idx = r_cnt[IDX_W-1:0];
                n_cnt           = CNT_W'(r_cnt + 1'b1);
                if (r_cnt == LAST) begin
                    n_state = jvcl_pkg::ST_HAND;
                end
            end
            jvcl_pkg::ST_HAND: begin
                // move result into the output register once it is free
                if (!r_out_vld || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = jvcl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jvcl_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != jvcl_pkg::ST_IDLE);
    assign o_valid = r_out_vld;

endmodule

FILE: sv/jvcl_dp.sv
// Datapath of the joint velocity command limiter: configuration registers,
// stored previous commands, a per-joint pipeline and result buffers.
// Depends on jvcl_pkg.
module jvcl_dp #(
    parameter int unsigned JOINT_COUNT = jvcl_pkg::JOINT_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [jvcl_pkg::CFG_AW-1:0]         i_cfg_idx,
    input  logic [jvcl_pkg::CFG_DW-1:0]         i_cfg_data,
    input  jvcl_pkg::t_in_req                   i_data,
    input  jvcl_pkg::t_ctrl_cmd                 i_cmd,
    output jvcl_pkg::t_out_rsp                  o_data
);

    localparam int unsigned LANES = jvcl_pkg::LANES;
    localparam int unsigned IDX_W = jvcl_pkg::IDX_W;

    // Configuration registers
    logic [16:0]        r_alpha;
    logic [15:0]        r_ctime;
    logic [19:0]        r_inv;
    logic [14:0]        r_climit;
    logic [14:0]        r_vlimit;
    logic [14:0]        r_slimit;
    logic signed [15:0] r_pos_min;
    logic signed [15:0] r_pos_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha   <= jvcl_pkg::ALPHA_RST;
            r_ctime   <= jvcl_pkg::CTIME_RST;
            r_inv     <= jvcl_pkg::INV_RST;
            r_climit  <= jvcl_pkg::CLIMIT_RST;
            r_vlimit  <= jvcl_pkg::VLIMIT_RST;
            r_slimit  <= jvcl_pkg::SLIMIT_RST;
            r_pos_min <= jvcl_pkg::POS_MIN_RST;
            r_pos_max <= jvcl_pkg::POS_MAX_RST;
        end else if (i_cfg_we) begin
            case (jvcl_pkg::t_cfg_idx'(i_cfg_idx))
                jvcl_pkg::CFG_ALPHA:   r_alpha   <= i_cfg_data[16:0];
                jvcl_pkg::CFG_CTIME:   r_ctime   <= i_cfg_data[15:0];
                jvcl_pkg::CFG_INV:     r_inv     <= i_cfg_data[19:0];
                jvcl_pkg::CFG_CLIMIT:  r_climit  <= i_cfg_data[14:0];
                jvcl_pkg::CFG_VLIMIT:  r_vlimit  <= i_cfg_data[14:0];
                jvcl_pkg::CFG_SLIMIT:  r_slimit  <= i_cfg_data[14:0];
                jvcl_pkg::CFG_POS_MIN: r_pos_min <= i_cfg_data[15:0];
                jvcl_pkg::CFG_POS_MAX: r_pos_max <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Unpack the incoming request into lanes
    logic signed [15:0] w_in_pos [LANES];
    logic signed [15:0] w_in_cmd [LANES];
    logic               w_all_zero;

    always_comb begin
        w_in_pos[0] = i_data.pos_now_0;
        w_in_pos[1] = i_data.pos_now_1;
        w_in_pos[2] = i_data.pos_now_2;
        w_in_pos[3] = i_data.pos_now_3;
        w_in_pos[4] = i_data.pos_now_4;
        w_in_pos[5] = i_data.pos_now_5;
        w_in_cmd[0] = i_data.vel_cmd_0;
        w_in_cmd[1] = i_data.vel_cmd_1;
        w_in_cmd[2] = i_data.vel_cmd_2;
        w_in_cmd[3] = i_data.vel_cmd_3;
        w_in_cmd[4] = i_data.vel_cmd_4;
        w_in_cmd[5] = i_data.vel_cmd_5;
    end

    // Zero request: every active joint commands zero
    always_comb begin
        w_all_zero = 1'b1;
        for (int i = 0; i < LANES; i++) begin
            if (i < JOINT_COUNT && w_in_cmd[i] != 16'sd0) begin
                w_all_zero = 1'b0;
            end
        end
    end

    // Latched request and filter mode
    logic signed [15:0] r_pos [LANES];
    logic signed [15:0] r_cmd [LANES];
    logic               r_raw;
    logic               r_prev_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pos <= w_in_pos;
            r_cmd <= w_in_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_vld <= 1'b0;
            r_raw      <= 1'b1;
        end else if (i_cmd.start) begin
            // zero or first request passes unfiltered
            r_raw      <= w_all_zero || !r_prev_vld;
            r_prev_vld <= !w_all_zero;
        end
    end

    // Stage 0: select joint, alpha times change against previous command
    logic signed [15:0] r_prev [LANES];
    logic [16:0]        w_alpha;
    logic signed [15:0] w_cmd_sel;
    logic signed [15:0] w_prev_sel;
    logic signed [16:0] w_diff;
    logic signed [34:0] w_prod1;

    assign w_alpha    = (r_alpha > jvcl_pkg::ALPHA_ONE) ? jvcl_pkg::ALPHA_ONE : r_alpha;
    assign w_cmd_sel  = r_cmd[i_cmd.issue_idx];
    assign w_prev_sel = r_prev[i_cmd.issue_idx];
    assign w_diff     = $signed({w_cmd_sel[15], w_cmd_sel}) - $signed({w_prev_sel[15], w_prev_sel});
    assign w_prod1    = $signed({1'b0, w_alpha}) * w_diff;

    logic               r_s1_vld;
    logic [IDX_W-1:0]   r_s1_idx;
    logic signed [34:0] r_s1_prod;
    logic signed [15:0] r_s1_cmd;
    logic signed [15:0] r_s1_prev;
    logic signed [15:0] r_s1_pos;

    // Stage 1: round, slew-limit, add to previous command
    logic signed [35:0] w_r1;
    logic signed [19:0] w_delta;
    logic signed [19:0] w_cl;
    logic signed [19:0] w_dcl;
    logic signed [20:0] w_sum;
    logic signed [15:0] w_sent;

    always_comb begin
        w_r1    = $signed({r_s1_prod[34], r_s1_prod}) + 36'sd32768;
        w_delta = w_r1[35:16];
        w_cl    = $signed({5'd0, r_climit});
        w_dcl   = w_delta;
        if (w_dcl < -w_cl) begin
            w_dcl = -w_cl;
        end
        if (w_dcl > w_cl) begin
            w_dcl = w_cl;
        end
        w_sum = $signed({{5{r_s1_prev[15]}}, r_s1_prev}) + $signed({w_dcl[19], w_dcl});
        if (r_raw) begin
            w_sent = r_s1_cmd;
        end else if (w_sum > 21'sd32767) begin
            w_sent = 16'sh7fff;
        end else if (w_sum < -21'sd32768) begin
            w_sent = -16'sd32768;
        end else begin
            w_sent = w_sum[15:0];
        end
    end

    // Stored previous commands, reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                r_prev[i] <= '0;
            end
        end else if (r_s1_vld) begin
            r_prev[r_s1_idx] <= w_sent;
        end
    end

    logic               r_s2_vld;
    logic [IDX_W-1:0]   r_s2_idx;
    logic signed [15:0] r_s2_sent;
    logic signed [15:0] r_s2_pos;

    // Stage 2: velocity clamp, step product
    logic signed [15:0] w_vl;
    logic signed [15:0] w_v;
    logic signed [32:0] w_prod2;

    always_comb begin
        w_vl = $signed({1'b0, r_vlimit});
        w_v  = r_s2_sent;
        if (w_v < -w_vl) begin
            w_v = -w_vl;
        end
        if (w_v > w_vl) begin
            w_v = w_vl;
        end
        w_prod2 = $signed({1'b0, r_ctime}) * w_v;
    end

    logic               r_s3_vld;
    logic [IDX_W-1:0]   r_s3_idx;
    logic signed [32:0] r_s3_prod;
    logic signed [15:0] r_s3_pos;

    // Stage 3: round step, step clamp, position clamp
    logic signed [33:0] w_r3;
    logic signed [17:0] w_step;
    logic signed [17:0] w_sl;
    logic signed [18:0] w_q;
    logic signed [18:0] w_pmin;
    logic signed [18:0] w_pmax;

    always_comb begin
        w_r3   = $signed({r_s3_prod[32], r_s3_prod}) + 34'sd32768;
        w_step = w_r3[33:16];
        w_sl   = $signed({3'd0, r_slimit});
        if (w_step < -w_sl) begin
            w_step = -w_sl;
        end
        if (w_step > w_sl) begin
            w_step = w_sl;
        end
        w_pmin = $signed({{3{r_pos_min[15]}}, r_pos_min});
        w_pmax = $signed({{3{r_pos_max[15]}}, r_pos_max});
        w_q    = $signed({{3{r_s3_pos[15]}}, r_s3_pos}) + $signed({w_step[17], w_step});
        // lower limit first, so the upper limit wins when they cross
        if (w_q < w_pmin) begin
            w_q = w_pmin;
        end
        if (w_q > w_pmax) begin
            w_q = w_pmax;
        end
    end

    logic               r_s4_vld;
    logic [IDX_W-1:0]   r_s4_idx;
    logic signed [15:0] r_s4_q;
    logic signed [15:0] r_s4_pos;

    // Stage 4: actual step times inverse command time
    logic signed [16:0] w_d;
    logic signed [37:0] w_prod4;

    assign w_d     = $signed({r_s4_q[15], r_s4_q}) - $signed({r_s4_pos[15], r_s4_pos});
    assign w_prod4 = w_d * $signed({1'b0, r_inv});

    logic               r_s5_vld;
    logic [IDX_W-1:0]   r_s5_idx;
    logic signed [37:0] r_s5_prod;
    logic signed [15:0] r_s5_q;

    // Stage 5: round and saturate effective velocity
    logic signed [38:0] w_r5;
    logic signed [30:0] w_veff;
    logic signed [15:0] w_veff_sat;

    always_comb begin
        w_r5   = $signed({r_s5_prod[37], r_s5_prod}) + 39'sd128;
        w_veff = w_r5[38:8];
        if (w_veff > 31'sd32767) begin
            w_veff_sat = 16'sh7fff;
        end else if (w_veff < -31'sd32768) begin
            w_veff_sat = -16'sd32768;
        end else begin
            w_veff_sat = w_veff[15:0];
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
        end
    end

    // Stage payload registers
    always_ff @(posedge i_clk) begin
        r_s1_idx  <= i_cmd.issue_idx;
        r_s1_prod <= w_prod1;
        r_s1_cmd  <= w_cmd_sel;
        r_s1_prev <= w_prev_sel;
        r_s1_pos  <= r_pos[i_cmd.issue_idx];

        r_s2_idx  <= r_s1_idx;
        r_s2_sent <= w_sent;
        r_s2_pos  <= r_s1_pos;

        r_s3_idx  <= r_s2_idx;
        r_s3_prod <= w_prod2;
        r_s3_pos  <= r_s2_pos;

        r_s4_idx  <= r_s3_idx;
        r_s4_q    <= w_q[15:0];
        r_s4_pos  <= r_s3_pos;

        r_s5_idx  <= r_s4_idx;
        r_s5_prod <= w_prod4;
        r_s5_q    <= r_s4_q;
    end

    // Result buffer, zero for inactive joints
    logic signed [15:0] r_res_pos [LANES];
    logic signed [15:0] r_res_vel [LANES];

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int i = 0; i < LANES; i++) begin
                r_res_pos[i] <= '0;
                r_res_vel[i] <= '0;
            end
        end else if (r_s5_vld) begin
            r_res_pos[r_s5_idx] <= r_s5_q;
            r_res_vel[r_s5_idx] <= w_veff_sat;
        end
    end

    // Output register
    jvcl_pkg::t_out_rsp r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.pos_next_0 <= r_res_pos[0];
            r_out.pos_next_1 <= r_res_pos[1];
            r_out.pos_next_2 <= r_res_pos[2];
            r_out.pos_next_3 <= r_res_pos[3];
            r_out.pos_next_4 <= r_res_pos[4];
            r_out.pos_next_5 <= r_res_pos[5];
            r_out.vel_eff_0  <= r_res_vel[0];
            r_out.vel_eff_1  <= r_res_vel[1];
            r_out.vel_eff_2  <= r_res_vel[2];
            r_out.vel_eff_3  <= r_res_vel[3];
            r_out.vel_eff_4  <= r_res_vel[4];
            r_out.vel_eff_5  <= r_res_vel[5];
        end
    end

    assign o_data = r_out;

endmodule

FILE: sv/joint_velocity_command_limiter.sv
// Joint velocity command limiter, top level: sequencer plus datapath.
// A new request is taken only after the current result has gone to the output;
// joints share one pipeline, one joint entering per cycle, then the pipe drains.
// Reset (synchronous, active low) restores register defaults, clears stored commands.
// Depends on jvcl_pkg, jvcl_ctrl, jvcl_dp.
module joint_velocity_command_limiter #(
    parameter int unsigned JOINT_COUNT = jvcl_pkg::JOINT_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [jvcl_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [jvcl_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  jvcl_pkg::t_in_req           i_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output jvcl_pkg::t_out_rsp          o_data
);

    jvcl_pkg::t_ctrl_cmd w_cmd;

    // Sequencer
    jvcl_ctrl #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    // Datapath
    jvcl_dp #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_data     (i_data),
        .i_cmd      (w_cmd),
        .o_data     (o_data)
    );

`ifndef NO_ASSERTIONS
    // block is busy right after taking a request
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |=> o_stall)
        else $error("no stall after request accept");

    // result valid rises only from an output load
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.load_out))
        else $error("result valid without load");

    // output register is never overwritten while a result is held
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_valid || !i_stall))
        else $error("held result overwritten");

    // joints are issued only while busy and never with a new request
    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.issue |-> (o_stall && !w_cmd.start))
        else $error("joint issued while idle");
`endif

endmodule
